@@ src/jsu_pkg.sv @@
// Types, codes and helpers for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  // Input word: one raw byte of the quoted string, or the end-of-text marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_word_t;

  // Output word: one decoded content byte, or a done/error marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EXP_QUOTE  = 3'd1,
    ERR_UNTERM_STR = 3'd2,
    ERR_UNTERM_ESC = 3'd3,
    ERR_BAD_ESC    = 3'd4,
    ERR_TRUNC_HEX  = 3'd5,
    ERR_BAD_HEX    = 3'd6
  } err_e;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_STR          = 4'd1,
    PH_ESC          = 4'd2,
    PH_HEX          = 4'd3,
    PH_HEX_BAD      = 4'd4,
    PH_HELD         = 4'd5,
    PH_HELD_ESC     = 4'd6,
    PH_HELD_HEX     = 4'd7,
    PH_HELD_HEX_BAD = 4'd8
  } phase_e;

  // Kind of the main part of the results for one input word.
  typedef enum logic [1:0] {
    MAIN_NONE = 2'd0,
    MAIN_BYTE = 2'd1,
    MAIN_UTF8 = 2'd2,
    MAIN_CTRL = 2'd3
  } main_e;

  // One buffered result, without the last flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  localparam int unsigned MaxRes = 6;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [15:0] SurHiLo = 16'hD800;
  localparam logic [15:0] SurHiHi = 16'hDBFF;
  localparam logic [15:0] SurLoLo = 16'hDC00;
  localparam logic [15:0] SurLoHi = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;

  // UTF-8 form of a code point; b[0] goes out first.
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/json_string_unescape_utf8.sv @@
// Top level of the streaming JSON string unescaper with UTF-8 output.
`default_nettype none

// Streaming JSON string unescaper. Feed the bytes of one double-quoted string
// (opening quote included) as words with kind 0, and kind 1 for end of text.
// Content comes out one UTF-8 byte per output word; \uXXXX escapes are
// encoded, surrogate pairs are joined into 4-byte sequences and a lone
// surrogate goes out in its 3-byte form. The closing quote gives a word with
// string_done set, malformed input a word with an error code; after either
// the block waits for a new opening quote. The final word caused by one
// input word carries last. Rate: while the output is not stalled, a word
// producing zero or one result does not hold back the next, so plain text
// streams at one byte per cycle; a word producing more results (up to six,
// for a flushed surrogate plus a 3-byte code point) holds the input until
// its final result leaves the six-entry result buffer by the single output
// port; the next word is taken in that cycle. No clearing pass after reset.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_word_t out_word_o
);

  // Parser state
  phase_e      ph_q, ph_d;
  logic [15:0] acc_q, acc_d;    // hex digits gathered so far
  logic [1:0]  seen_q, seen_d;  // number of hex digits gathered
  logic [15:0] hi_q, hi_d;      // held high surrogate
  logic        hv_q, hv_d;

  // Result buffer
  res_t        res_q [MaxRes];
  res_t        res_d [MaxRes];
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  ptr_q, ptr_d;

  logic        in_acc, pop, pop_last, is_last;

  // Step decode results
  logic        flush;
  main_e       mk;
  logic [7:0]  m_byte;
  logic [20:0] m_cp;
  logic        m_done;
  err_e        m_err;
  logic [2:0]  new_cnt;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    // bit 4 set marks a non-hex character
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Single-character escapes; bit 8 set means no such escape.
  function automatic logic [8:0] esc_value(input logic [7:0] c);
    logic [8:0] v;
    unique case (c)
      8'h22:   v = 9'h022;
      8'h5C:   v = 9'h05C;
      8'h2F:   v = 9'h02F;
      8'h62:   v = 9'h008;
      8'h66:   v = 9'h00C;
      8'h6E:   v = 9'h00A;
      8'h72:   v = 9'h00D;
      8'h74:   v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // One step of the parser: next state plus the result list for this word.
  // Results are an optional 3-byte flush of the held surrogate followed by
  // an optional main part (raw byte, UTF-8 sequence, or a done/error marker).
  // ---------------------------------------------------------------------
  always_comb begin
    logic [7:0]  c;
    logic [4:0]  hv;
    logic [8:0]  ev;
    logic        bad;
    logic [15:0] acc_n;
    logic        held;

    c      = in_word_i.text_byte;
    hv     = hex_value(c);
    ev     = esc_value(c);
    held   = (ph_q == PH_HELD_HEX) || (ph_q == PH_HELD_HEX_BAD);
    bad    = (ph_q == PH_HEX_BAD) || (ph_q == PH_HELD_HEX_BAD) || hv[4];
    acc_n  = {acc_q[11:0], hv[4] ? 4'h0 : hv[3:0]};

    ph_d   = ph_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    hi_d   = hi_q;
    hv_d   = hv_q;
    flush  = 1'b0;
    mk     = MAIN_NONE;
    m_byte = '0;
    m_cp   = '0;
    m_done = 1'b0;
    m_err  = ERR_NONE;

    if (in_word_i.kind) begin
      // end of text
      unique case (ph_q)
        PH_STR, PH_HELD: begin
          flush = hv_q;
          mk    = MAIN_CTRL;
          m_err = ERR_UNTERM_STR;
        end
        PH_ESC, PH_HELD_ESC: begin
          flush = hv_q;
          mk    = MAIN_CTRL;
          m_err = ERR_UNTERM_ESC;
        end
        PH_HEX, PH_HEX_BAD, PH_HELD_HEX, PH_HELD_HEX_BAD: begin
          flush = hv_q;
          mk    = MAIN_CTRL;
          m_err = ERR_TRUNC_HEX;
        end
        default: ;
      endcase
      ph_d   = PH_IDLE;
      acc_d  = '0;
      seen_d = '0;
      hi_d   = '0;
      hv_d   = 1'b0;
    end else begin
      unique case (ph_q)
        PH_STR, PH_HELD: begin
          if (c == ChBslash) begin
            ph_d = (ph_q == PH_HELD) ? PH_HELD_ESC : PH_ESC;
          end else begin
            flush = hv_q;
            hi_d  = '0;
            hv_d  = 1'b0;
            if (c == ChQuote) begin
              mk     = MAIN_CTRL;
              m_done = 1'b1;
              acc_d  = '0;
              seen_d = '0;
              ph_d   = PH_IDLE;
            end else begin
              mk     = MAIN_BYTE;
              m_byte = c;
              ph_d   = PH_STR;
            end
          end
        end
        PH_ESC, PH_HELD_ESC: begin
          if (c == ChU) begin
            acc_d  = '0;
            seen_d = '0;
            ph_d   = (ph_q == PH_HELD_ESC) ? PH_HELD_HEX : PH_HEX;
          end else begin
            flush = hv_q;
            hi_d  = '0;
            hv_d  = 1'b0;
            if (ev[8]) begin
              mk     = MAIN_CTRL;
              m_err  = ERR_BAD_ESC;
              acc_d  = '0;
              seen_d = '0;
              ph_d   = PH_IDLE;
            end else begin
              mk     = MAIN_BYTE;
              m_byte = ev[7:0];
              ph_d   = PH_STR;
            end
          end
        end
        PH_HEX, PH_HEX_BAD, PH_HELD_HEX, PH_HELD_HEX_BAD: begin
          if (seen_q != 2'd3) begin
            acc_d  = acc_n;
            seen_d = seen_q + 2'd1;
            if (bad) begin
              ph_d = held ? PH_HELD_HEX_BAD : PH_HEX_BAD;
            end
          end else begin
            acc_d  = '0;
            seen_d = '0;
            if (bad) begin
              flush = hv_q;
              mk    = MAIN_CTRL;
              m_err = ERR_BAD_HEX;
              hi_d  = '0;
              hv_d  = 1'b0;
              ph_d  = PH_IDLE;
            end else if (held && acc_n >= SurLoLo && acc_n <= SurLoHi) begin
              // surrogate pair joins into one supplementary code point
              mk   = MAIN_UTF8;
              m_cp = SuppBase + {1'b0, hi_q[9:0], acc_n[9:0]};
              hi_d = '0;
              hv_d = 1'b0;
              ph_d = PH_STR;
            end else begin
              flush = hv_q;
              if (acc_n >= SurHiLo && acc_n <= SurHiHi) begin
                hi_d = acc_n;
                hv_d = 1'b1;
                ph_d = PH_HELD;
              end else begin
                mk   = MAIN_UTF8;
                m_cp = {5'd0, acc_n};
                hi_d = '0;
                hv_d = 1'b0;
                ph_d = PH_STR;
              end
            end
          end
        end
        default: begin
          // idle: wait for the opening quote
          acc_d  = '0;
          seen_d = '0;
          hi_d   = '0;
          hv_d   = 1'b0;
          if (c == ChQuote) begin
            ph_d = PH_STR;
          end else begin
            mk    = MAIN_CTRL;
            m_err = ERR_EXP_QUOTE;
            ph_d  = PH_IDLE;
          end
        end
      endcase
    end
  end

  // Assemble the result list
  always_comb begin
    utf8_t      fl_enc, m_enc;
    res_t       f [3];
    res_t       m [MaxRes];
    logic [2:0] mlen;
    logic [2:0] off;
    logic [2:0] idx;

    fl_enc = utf8_encode({5'd0, hi_q});
    m_enc  = utf8_encode(m_cp);
    for (int k = 0; k < 3; k++) begin
      f[k] = '{out_byte: fl_enc.b[k], byte_valid: 1'b1, string_done: 1'b0,
               error_code: ERR_NONE};
    end
    for (int k = 0; k < MaxRes; k++) begin
      m[k] = '0;
    end
    unique case (mk)
      MAIN_BYTE: begin
        m[0] = '{out_byte: m_byte, byte_valid: 1'b1, string_done: 1'b0,
                 error_code: ERR_NONE};
        mlen = 3'd1;
      end
      MAIN_UTF8: begin
        for (int k = 0; k < 4; k++) begin
          m[k] = '{out_byte: m_enc.b[k], byte_valid: 1'b1, string_done: 1'b0,
                   error_code: ERR_NONE};
        end
        mlen = m_enc.len;
      end
      MAIN_CTRL: begin
        m[0] = '{out_byte: 8'h00, byte_valid: 1'b0, string_done: m_done,
                 error_code: m_err};
        mlen = 3'd1;
      end
      default: mlen = 3'd0;
    endcase

    off     = flush ? 3'd3 : 3'd0;
    new_cnt = off + mlen;
    for (int i = 0; i < MaxRes; i++) begin
      idx = 3'(i) - off;
      if (flush && i < 3) begin
        res_d[i] = f[i];
      end else begin
        res_d[i] = m[idx];
      end
    end
  end

  // Handshake and buffer control
  assign out_valid_o = (cnt_q != 3'd0);
  assign is_last     = (ptr_q == cnt_q - 3'd1);
  assign pop         = out_valid_o && !out_stall_i;
  assign pop_last    = pop && is_last;
  assign in_stall_o  = out_valid_o && !pop_last;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    res_t r;
    r = res_q[ptr_q];
    out_word_o = '{out_byte: r.out_byte, byte_valid: r.byte_valid,
                   string_done: r.string_done, error_code: r.error_code,
                   last: is_last};
  end

  always_comb begin
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    if (pop) begin
      if (is_last) begin
        cnt_d = 3'd0;
        ptr_d = 3'd0;
      end else begin
        ptr_d = ptr_q + 3'd1;
      end
    end
    if (in_acc) begin
      cnt_d = new_cnt;
      ptr_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      acc_q  <= '0;
      seen_q <= '0;
      hi_q   <= '0;
      hv_q   <= 1'b0;
      cnt_q  <= '0;
      ptr_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (in_acc) begin
        ph_q   <= ph_d;
        acc_q  <= acc_d;
        seen_q <= seen_d;
        hi_q   <= hi_d;
        hv_q   <= hv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  // Assertions
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ptr_q < cnt_q) && (cnt_q <= 3'(MaxRes)))
    else $error("result pointer beyond buffer fill");

  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> (ph_q == PH_HELD) || (ph_q == PH_HELD_ESC) ||
             (ph_q == PH_HELD_HEX) || (ph_q == PH_HELD_HEX_BAD))
    else $error("held surrogate outside a held phase");

  a_hex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != 2'd0) |-> (ph_q == PH_HEX) || (ph_q == PH_HEX_BAD) ||
                         (ph_q == PH_HELD_HEX) || (ph_q == PH_HELD_HEX_BAD))
    else $error("hex digit count outside a hex escape");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.string_done || (out_word_o.error_code != ERR_NONE))
      |-> out_word_o.last && !out_word_o.byte_valid)
    else $error("done or error word is not the final byteless result");

  a_pop_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !is_last |=> out_valid_o && (ptr_q == $past(ptr_q) + 3'd1))
    else $error("result buffer did not advance after a taken word");

endmodule

`default_nettype wire
